FILE: rtl/core/crcfr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the CRC-8 frame receiver.
package crcfr_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h55;
  localparam logic [7:0] TAIL_FIRST  = 8'hCC;
  localparam logic [7:0] TAIL_SECOND = 8'h33;
  localparam logic [7:0] CRC_TOP     = 8'h80;
  localparam logic [7:0] POLY_RESET  = 8'h07;

  // Frame parser phases
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_HDR2  = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_CRC   = 6'b001000,
    PH_TAIL1 = 6'b010000,
    PH_TAIL2 = 6'b100000
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TAIL_ERR = 2'd2
  } status_t;

  // One finished frame, handed from parser to playback
  typedef struct packed {
    status_t status;
    logic    bank;
  } cmd_t;

  // Playback has finished reading a payload bank
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/crcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/crcfr_front.sv
// Frame parser: header hunt, CRC accumulation, payload capture into a bank, verdict.
module crcfr_front #(
  parameter int PAYLOAD_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic [7:0]                        poly,
  output logic                              q_push,
  output crcfr_pkg::cmd_t                   q_cmd,
  input  logic                              q_full,
  input  crcfr_pkg::release_t               rel,
  output logic                              ram_we,
  output logic [$clog2(2*PAYLOAD_LEN)-1:0]  ram_waddr,
  output logic [7:0]                        ram_wdata
);

  localparam int IW = $clog2(PAYLOAD_LEN + 1);
  localparam int AW = $clog2(2 * PAYLOAD_LEN);

  crcfr_pkg::phase_t phase_r, phase_nxt;
  logic [IW-1:0]     count_r, count_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [7:0]        rx_crc_r, rx_crc_nxt;
  logic              tail1_ok_r, tail1_ok_nxt;
  logic              wr_bank_r, wr_bank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic              acc;
  logic [7:0]        crc_upd;

  // Stall only where a payload bank is still being played or the queue is full
  assign in_tready = !((phase_r == crcfr_pkg::PH_DATA) && busy_r[wr_bank_r]) &&
                     !((phase_r == crcfr_pkg::PH_TAIL2) && q_full);
  assign acc       = in_tvalid && in_tready;
  assign crc_upd   = crcfr_pkg::crc8_byte(crc_r, in_tdata, poly);

  assign ram_wdata = in_tdata;
  assign ram_waddr = (wr_bank_r ? AW'(PAYLOAD_LEN) : AW'(0)) + AW'(count_r);

  // Parser next state
  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    rx_crc_nxt   = rx_crc_r;
    tail1_ok_nxt = tail1_ok_r;
    wr_bank_nxt  = wr_bank_r;
    busy_nxt     = busy_r;
    ram_we       = 1'b0;
    q_push       = 1'b0;
    q_cmd.bank   = wr_bank_r;
    q_cmd.status = crcfr_pkg::ST_GOOD;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (rx_crc_r != crc_r) begin
      q_cmd.status = crcfr_pkg::ST_CRC_ERR;
    end else if (!(tail1_ok_r && in_tdata == crcfr_pkg::TAIL_SECOND)) begin
      q_cmd.status = crcfr_pkg::ST_TAIL_ERR;
    end

    if (acc) begin
      unique case (phase_r)
        crcfr_pkg::PH_HDR2: begin
          if (in_tdata == crcfr_pkg::HDR_SECOND) begin
            crc_nxt   = crc_upd;
            count_nxt = '0;
            phase_nxt = crcfr_pkg::PH_DATA;
          end else begin
            phase_nxt = crcfr_pkg::PH_HUNT;
            count_nxt = '0;
            crc_nxt   = 8'h00;
          end
        end
        crcfr_pkg::PH_DATA: begin
          ram_we    = 1'b1;
          crc_nxt   = crc_upd;
          count_nxt = count_r + IW'(1);
          if (count_nxt == IW'(PAYLOAD_LEN)) begin
            phase_nxt = crcfr_pkg::PH_CRC;
          end
        end
        crcfr_pkg::PH_CRC: begin
          rx_crc_nxt = in_tdata;
          phase_nxt  = crcfr_pkg::PH_TAIL1;
        end
        crcfr_pkg::PH_TAIL1: begin
          tail1_ok_nxt = (in_tdata == crcfr_pkg::TAIL_FIRST);
          phase_nxt    = crcfr_pkg::PH_TAIL2;
        end
        crcfr_pkg::PH_TAIL2: begin
          q_push = 1'b1;
          // A good frame hands its bank to playback; fill the other one next
          if (q_cmd.status == crcfr_pkg::ST_GOOD) begin
            busy_nxt[wr_bank_r] = 1'b1;
            wr_bank_nxt         = !wr_bank_r;
          end
          phase_nxt = crcfr_pkg::PH_HUNT;
          count_nxt = '0;
          crc_nxt   = 8'h00;
        end
        default: begin
          count_nxt = '0;
          if (in_tdata == crcfr_pkg::HDR_FIRST) begin
            crc_nxt   = crcfr_pkg::crc8_byte(8'h00, in_tdata, poly);
            phase_nxt = crcfr_pkg::PH_HDR2;
          end else begin
            crc_nxt   = 8'h00;
            phase_nxt = crcfr_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= crcfr_pkg::PH_HUNT;
      count_r    <= '0;
      crc_r      <= 8'h00;
      rx_crc_r   <= 8'h00;
      tail1_ok_r <= 1'b0;
      wr_bank_r  <= 1'b0;
      busy_r     <= 2'b00;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      rx_crc_r   <= rx_crc_nxt;
      tail1_ok_r <= tail1_ok_nxt;
      wr_bank_r  <= wr_bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

FILE: rtl/core/crcfr_cmd_q.sv
// Two-entry queue of frame verdicts between parser and playback.
module crcfr_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crcfr_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output crcfr_pkg::cmd_t head
);

  crcfr_pkg::cmd_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
      count_nxt  = count_nxt + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
      count_nxt  = count_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/crcfr_back.sv
// Playback: turns verdicts into results, reading good payloads out of the bank RAM.
module crcfr_back #(
  parameter int PAYLOAD_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  crcfr_pkg::cmd_t                   q_head,
  output logic                              q_pop,
  output crcfr_pkg::release_t               rel,
  output logic                              ram_re,
  output logic [$clog2(2*PAYLOAD_LEN)-1:0]  ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  output logic [1:0]                        out_tuser
);

  localparam int IW = $clog2(PAYLOAD_LEN + 1);
  localparam int AW = $clog2(2 * PAYLOAD_LEN);

  logic              busy_r, busy_nxt;
  logic              bank_r, bank_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic              oval_r, oval_nxt;
  logic [7:0]        odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  crcfr_pkg::status_t ostat_r, ostat_nxt;
  logic              out_free;
  logic              issue;
  logic              start;
  logic              err;

  assign out_free  = !oval_r || out_tready;
  assign issue     = busy_r && !rd_pend_r && out_free;
  assign start     = !busy_r && !rd_pend_r && q_valid && (q_head.status == crcfr_pkg::ST_GOOD);
  assign err       = !busy_r && !rd_pend_r && q_valid && (q_head.status != crcfr_pkg::ST_GOOD) &&
                     out_free;
  assign q_pop     = start || err;
  assign ram_re    = issue;
  assign ram_raddr = (bank_r ? AW'(PAYLOAD_LEN) : AW'(0)) + AW'(idx_r);
  assign rel.valid = rd_pend_r && rd_last_r;
  assign rel.bank  = bank_r;

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ostat_r;

  // Playback sequencing and output register
  always_comb begin
    busy_nxt    = busy_r;
    bank_nxt    = bank_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    oval_nxt    = oval_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    ostat_nxt   = ostat_r;

    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    if (start) begin
      busy_nxt = 1'b1;
      bank_nxt = q_head.bank;
      idx_nxt  = '0;
    end

    if (issue) begin
      rd_pend_nxt = 1'b1;
      rd_last_nxt = (idx_r == IW'(PAYLOAD_LEN - 1));
      idx_nxt     = idx_r + IW'(1);
      if (idx_r == IW'(PAYLOAD_LEN - 1)) begin
        busy_nxt = 1'b0;
      end
    end

    // Read data lands in the cycle after the request; output is free by then
    if (rd_pend_r) begin
      oval_nxt  = 1'b1;
      odata_nxt = ram_rdata;
      olast_nxt = rd_last_r;
      ostat_nxt = crcfr_pkg::ST_GOOD;
    end else if (err) begin
      oval_nxt  = 1'b1;
      odata_nxt = 8'h00;
      olast_nxt = 1'b1;
      ostat_nxt = q_head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rd_pend_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      rd_pend_r <= rd_pend_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r    <= bank_nxt;
    idx_r     <= idx_nxt;
    rd_last_r <= rd_last_nxt;
    odata_r   <= odata_nxt;
    olast_r   <= olast_nxt;
    ostat_r   <= ostat_nxt;
  end

endmodule

FILE: rtl/core/crc8_frame_receiver.sv
// Top level of the CRC-8 framed byte receiver.
// Accepts one received byte per cycle and parses frames of AA 55, PAYLOAD_LEN payload
// bytes, one CRC-8 byte (MSB first, init 0, polynomial from cfg_data, reset 0x07, over
// both header bytes and the payload) and tail CC 33. A good frame is replayed as
// PAYLOAD_LEN results with tlast on the final byte and tuser 0; a bad frame gives one
// result with data 0, tlast set and tuser 1 (CRC mismatch, takes precedence) or 2 (tail
// mismatch). Payload goes into a two-bank RAM, so the parser can take a new frame while
// the previous one is still being played out; it stalls only when it would overwrite a
// bank still being played or when the two-entry verdict queue is full. Playback requests
// the next payload byte only once the previous registered RAM read has reached the
// output register; an error result goes straight into the output register.
module crc8_frame_receiver #(
  parameter int PAYLOAD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser,  // [1:0] status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(2 * PAYLOAD_LEN);

  logic [7:0]          poly_r;
  logic                q_push;
  crcfr_pkg::cmd_t     q_cmd;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  crcfr_pkg::cmd_t     q_head;
  crcfr_pkg::release_t rel;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  // Polynomial register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= crcfr_pkg::POLY_RESET;
    end else if (cfg_valid) begin
      poly_r <= cfg_data;
    end
  end

  crcfr_front #(.PAYLOAD_LEN(PAYLOAD_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .poly      (poly_r),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  crcfr_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  crcfr_ram #(.WIDTH(8), .DEPTH(2 * PAYLOAD_LEN)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crcfr_back #(.PAYLOAD_LEN(PAYLOAD_LEN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rel        (rel),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: dv/tb_top.sv
// Testbench for the CRC-8 frame receiver: directed and random byte streams checked per result.
`timescale 1ns / 1ps

module tb_top;

  localparam int PAYLOAD_LEN    = 32;
  localparam int IDX_W          = $clog2(PAYLOAD_LEN);
  localparam int FRAME_BYTES    = PAYLOAD_LEN + 5;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int HOLD_CYCLES    = 300;

  // How a sent frame is built
  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_TAIL1,
    FR_BAD_TAIL2,
    FR_BAD_BOTH,
    FR_CUT
  } frame_kind_t;

  // How a payload is filled
  typedef enum int {
    PL_RANDOM,
    PL_ZERO,
    PL_ONES,
    PL_MARKERS,
    PL_COUNT
  } payload_kind_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    crcfr_pkg::status_t status;
  } frame_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] rx_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] out_byte
  logic       out_tlast;
  logic [1:0] out_tuser;            // [1:0] status
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = 8'h00;

  // Parser model state
  crcfr_pkg::phase_t model_phase;
  logic [6:0] model_count;
  logic [7:0] model_crc;
  logic [7:0] model_rx_crc;
  logic       model_tail1_ok;
  logic [7:0] model_poly;
  logic [7:0] model_store [PAYLOAD_LEN];

  frame_result_t frame_results_due[$];
  logic [7:0]    frame_payload [PAYLOAD_LEN];

  // Traffic shaping and bookkeeping
  int tx_gaps_on         = 0;
  int rx_stalls_on       = 0;
  int hold_request       = 0;
  int hold_left          = 0;
  int stall_left         = 0;
  int cycle_count        = 0;
  int error_count        = 0;
  int bytes_sent         = 0;
  int results_predicted  = 0;
  int results_checked    = 0;
  int frames_good        = 0;
  int frames_crc_err     = 0;
  int frames_tail_err    = 0;
  int poly_writes        = 0;
  int input_stall_cycles = 0;

  crc8_frame_receiver #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-8, MSB first, one data bit per shift
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return acc;
  endfunction

  // Mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic restart_model();
    model_phase = crcfr_pkg::PH_HUNT;
    model_count = '0;
    model_crc   = 8'h00;
  endtask

  // Advance the parser model by one accepted byte and queue what it releases
  task automatic track_frame_byte(input logic [7:0] b);
    frame_result_t r;
    case (model_phase)
      crcfr_pkg::PH_HDR2: begin
        if (b == crcfr_pkg::HDR_SECOND) begin
          model_crc   = crc8_next(model_crc, b, model_poly);
          model_count = '0;
          model_phase = crcfr_pkg::PH_DATA;
        end else begin
          restart_model();
        end
      end
      crcfr_pkg::PH_DATA: begin
        if (model_count < PAYLOAD_LEN) model_store[model_count[IDX_W-1:0]] = b;
        model_crc   = crc8_next(model_crc, b, model_poly);
        model_count = model_count + 7'd1;
        if (model_count >= PAYLOAD_LEN) model_phase = crcfr_pkg::PH_CRC;
      end
      crcfr_pkg::PH_CRC: begin
        model_rx_crc = b;
        model_phase  = crcfr_pkg::PH_TAIL1;
      end
      crcfr_pkg::PH_TAIL1: begin
        model_tail1_ok = (b == crcfr_pkg::TAIL_FIRST);
        model_phase    = crcfr_pkg::PH_TAIL2;
      end
      crcfr_pkg::PH_TAIL2: begin
        // CRC mismatch wins over a bad tail
        if (model_rx_crc != model_crc) begin
          r = '{data: 8'h00, last: 1'b1, status: crcfr_pkg::ST_CRC_ERR};
          frame_results_due.push_back(r);
          results_predicted++;
          frames_crc_err++;
        end else if (!(model_tail1_ok && b == crcfr_pkg::TAIL_SECOND)) begin
          r = '{data: 8'h00, last: 1'b1, status: crcfr_pkg::ST_TAIL_ERR};
          frame_results_due.push_back(r);
          results_predicted++;
          frames_tail_err++;
        end else begin
          for (int k = 0; k < PAYLOAD_LEN; k++) begin
            r = '{data: model_store[k], last: (k == PAYLOAD_LEN - 1),
                  status: crcfr_pkg::ST_GOOD};
            frame_results_due.push_back(r);
            results_predicted++;
          end
          frames_good++;
        end
        restart_model();
      end
      default: begin
        if (b == crcfr_pkg::HDR_FIRST) begin
          model_crc   = crc8_next(8'h00, b, model_poly);
          model_count = '0;
          model_phase = crcfr_pkg::PH_HDR2;
        end else begin
          restart_model();
        end
      end
    endcase
  endtask

  // Offer one byte and return at the edge it is taken; valid stays up for a follow-on
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_frame_byte(b);
    bytes_sent++;
  endtask

  // Must follow the last send directly, so valid drops at the accepting edge
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Finish any open frame, drain, then write the polynomial
  task automatic set_polynomial(input logic [7:0] p);
    while (model_phase != crcfr_pkg::PH_HUNT) send_byte(8'h00);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_poly = p;
    poly_writes++;
  endtask

  task automatic fill_payload(input payload_kind_t kind);
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      case (kind)
        PL_ZERO:  frame_payload[k] = 8'h00;
        PL_ONES:  frame_payload[k] = 8'hFF;
        PL_MARKERS: begin
          case (k % 4)
            0:       frame_payload[k] = crcfr_pkg::HDR_FIRST;
            1:       frame_payload[k] = crcfr_pkg::HDR_SECOND;
            2:       frame_payload[k] = crcfr_pkg::TAIL_FIRST;
            default: frame_payload[k] = crcfr_pkg::TAIL_SECOND;
          endcase
        end
        PL_COUNT: frame_payload[k] = 8'(k * 9);
        default:  frame_payload[k] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  // Build header, payload, CRC and tail, corrupt as asked, and send
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] crc;
    logic [7:0] flip;
    logic [7:0] bytes [FRAME_BYTES];
    int         count;
    crc = crc8_next(crc8_next(8'h00, crcfr_pkg::HDR_FIRST, model_poly),
                    crcfr_pkg::HDR_SECOND, model_poly);
    bytes[0] = crcfr_pkg::HDR_FIRST;
    bytes[1] = crcfr_pkg::HDR_SECOND;
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      bytes[k + 2] = frame_payload[k];
      crc = crc8_next(crc, frame_payload[k], model_poly);
    end
    bytes[PAYLOAD_LEN + 2] = crc;
    bytes[PAYLOAD_LEN + 3] = crcfr_pkg::TAIL_FIRST;
    bytes[PAYLOAD_LEN + 4] = crcfr_pkg::TAIL_SECOND;
    flip  = 8'h01 << $urandom_range(0, 7);
    count = FRAME_BYTES;
    case (kind)
      FR_BAD_CRC:   bytes[PAYLOAD_LEN + 2] ^= flip;
      FR_BAD_TAIL1: bytes[PAYLOAD_LEN + 3] ^= flip;
      FR_BAD_TAIL2: bytes[PAYLOAD_LEN + 4] ^= flip;
      FR_BAD_BOTH: begin
        bytes[PAYLOAD_LEN + 2] ^= flip;
        bytes[PAYLOAD_LEN + 3] ^= flip;
      end
      FR_CUT:       count = $urandom_range(1, FRAME_BYTES - 1);
      default: ;
    endcase
    for (int k = 0; k < count; k++) send_byte(bytes[k]);
  endtask

  // Good frame sent back to back; header and tail bytes inside the payload are plain data
  task automatic test_good_frames();
    tx_gaps_on   = 0;
    rx_stalls_on = 0;
    fill_payload(PL_MARKERS);
    send_frame(FR_GOOD);
    wait_idle();
  endtask

  // Header hunting: stray bytes, wrong second header byte, no reuse of that byte
  task automatic test_header_hunt();
    tx_gaps_on   = 1;
    rx_stalls_on = 1;
    send_byte(crcfr_pkg::HDR_SECOND);
    send_byte(crcfr_pkg::HDR_FIRST);
    send_byte(8'h00);
    // second AA is consumed as a bad second byte, so the 55 is ignored
    send_byte(crcfr_pkg::HDR_FIRST);
    send_byte(crcfr_pkg::HDR_FIRST);
    send_byte(crcfr_pkg::HDR_SECOND);
    send_byte(crcfr_pkg::TAIL_FIRST);
    send_byte(crcfr_pkg::TAIL_SECOND);
    wait_idle();
  endtask

  // Bad CRC and bad tail together: the CRC verdict wins
  task automatic test_bad_frames();
    tx_gaps_on   = 1;
    rx_stalls_on = 1;
    fill_payload(PL_RANDOM);
    send_frame(FR_BAD_BOTH);
    wait_idle();
  endtask

  // Switch to another polynomial; the frames that follow are built and checked with it
  task automatic test_polynomials();
    tx_gaps_on   = 1;
    rx_stalls_on = 1;
    set_polynomial(8'h9B);
  endtask

  // Receiver holds off while frames keep coming, so both banks fill and input stalls
  task automatic test_backpressure();
    tx_gaps_on   = 0;
    rx_stalls_on = 0;
    hold_request = HOLD_CYCLES;
    fill_payload(PL_ZERO);
    send_frame(FR_GOOD);
    fill_payload(PL_ONES);
    send_frame(FR_GOOD);
    // tail error verdict queued behind the second payload, which still has to play out
    fill_payload(PL_COUNT);
    send_frame(FR_BAD_TAIL2);
    wait_idle();
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_stalls_on != 0 && $urandom_range(0, 99) < 30) stall_left = idle_length();
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result data=%02h last=%0b status=%0d",
                 $time, out_tdata, out_tlast, out_tuser);
        error_count++;
      end else begin
        due = frame_results_due.pop_front();
        results_checked++;
        if (out_tdata !== due.data) begin
          $display("%0t: out_tdata expected %02h actual %02h", $time, due.data, out_tdata);
          error_count++;
        end
        if (out_tlast !== due.last) begin
          $display("%0t: out_tlast expected %0b actual %0b", $time, due.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== due.status) begin
          $display("%0t: out_tuser expected %0d actual %0d", $time, due.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Cycle budget and input stall count
  always @(posedge clk) begin
    cycle_count++;
    if (in_tvalid && !in_tready) input_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_results_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    model_poly     = crcfr_pkg::POLY_RESET;
    model_rx_crc   = 8'h00;
    model_tail1_ok = 1'b0;
    restart_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_good_frames();
    test_header_hunt();
    test_bad_frames();
    test_polynomials();
    test_backpressure();

    $display("sent %0d bytes, checked %0d results: %0d good, %0d CRC error, %0d tail error",
             bytes_sent, results_checked, frames_good, frames_crc_err, frames_tail_err);
    $display("%0d polynomial writes, %0d cycles with input held back", poly_writes,
             input_stall_cycles);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
